[rtl/vector_to_hue_degrees_assert.svh]
// assertion macros for the vector to hue block
// used by the top level; no other dependencies
`ifndef VECTOR_TO_HUE_DEGREES_ASSERT_SVH
`define VECTOR_TO_HUE_DEGREES_ASSERT_SVH

`ifndef SYNTHESIS
`define V2H_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("v2h assertion failed");
`define V2H_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("v2h assertion failed");
`else
`define V2H_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define V2H_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/v2h_pkg.sv]
// shared constants, types and the arctangent table of the vector to hue block
// no dependencies
package v2h_pkg;

	localparam int ITERATIONS  = 16;
	localparam int TABLE_LEN   = 24;
	localparam int NUM_CELLS   = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
	localparam int TBL_IDX_W   = $clog2(TABLE_LEN);
	localparam int GUARD_BITS  = 8;
	localparam int IN_W        = 16;
	localparam int OUT_W       = 16;
	localparam int XW          = 27;
	localparam int ZW          = 27;
	localparam int ATAN_W      = 22;
	localparam int OUT_SHIFT   = 9;
	localparam int RES_W       = ZW - OUT_SHIFT;

	localparam logic signed [ZW-1:0] DEG_HALF_TURN = ZW'(180 * 65536);
	localparam logic signed [ZW-1:0] DEG_FULL_TURN = ZW'(360 * 65536);
	localparam logic [ZW-1:0]        ROUND_HALF    = ZW'(256);
	localparam logic [OUT_W-1:0]     OUT_FULL_TURN = OUT_W'(46080);

	// atan(2^-i) in degrees, 16 fractional bits
	localparam logic [ATAN_W-1:0] ATAN_TBL [TABLE_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0
	};

	typedef struct packed {
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} v2h_rot_t;

endpackage

[rtl/v2h_if.sv]
// channel interfaces: vector input and hue output
// depends on v2h_pkg
interface v2h_vec_if
	import v2h_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] x_in;
	logic signed [IN_W-1:0] y_in;

	modport source (output valid, x_in, y_in, input ready);
	modport sink (input valid, x_in, y_in, output ready);
endinterface

interface v2h_hue_if
	import v2h_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] hue_deg;

	modport source (output valid, hue_deg, input ready);
	modport sink (input valid, hue_deg, output ready);
endinterface

[rtl/vector_to_hue_degrees.sv]
// top level of the vector to hue block: fold stage, chain of cordic cells, output stage
// depends on v2h_pkg, v2h_if, v2h_fold, v2h_cell, v2h_wrap and the assertion macros
//
// usage:
//   vec carries one signed vector (x_in, y_in) per transfer, 14 fractional bits each.
//   hue carries one hue_deg per vector: degrees times 128 in 0..46079, in input order.
//   a zero vector gives 0; an angle that rounds to a full turn gives 0.
// path: the input transfer loads the fold register, then each micro-rotation cell
//   register in turn and then the output register, which drives hue.valid.
// throughput: one vector per cycle unless stalled; each cell is a pipeline stage.
// stalls: each stage takes new data when it is empty or its successor moves, so
//   while hue.ready is low the chain keeps filling its empty stages and vec.ready
//   drops only once every stage holds a vector. the output register holds its
//   value until the transfer completes.
// reset: arst_n low clears every valid flag at once; the data registers are not
//   reset. the block accepts vectors in the first cycle after reset is released.
`include "vector_to_hue_degrees_assert.svh"

module vector_to_hue_degrees
	import v2h_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	v2h_vec_if.sink    vec,
	v2h_hue_if.source  hue
);

	logic     chain_valid [NUM_CELLS+1];
	logic     chain_ready [NUM_CELLS+1];
	v2h_rot_t chain_rot   [NUM_CELLS+1];

	v2h_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vec.valid),
		.up_ready (vec.ready),
		.x_in     (vec.x_in),
		.y_in     (vec.y_in),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_rot   (chain_rot[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		v2h_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_idx (TBL_IDX_W'(i)),
			.up_valid  (chain_valid[i]),
			.up_ready  (chain_ready[i]),
			.up_rot    (chain_rot[i]),
			.dn_valid  (chain_valid[i+1]),
			.dn_ready  (chain_ready[i+1]),
			.dn_rot    (chain_rot[i+1])
		);
	end

	v2h_wrap u_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[NUM_CELLS]),
		.up_ready (chain_ready[NUM_CELLS]),
		.up_rot   (chain_rot[NUM_CELLS]),
		.dn_valid (hue.valid),
		.dn_ready (hue.ready),
		.hue_deg  (hue.hue_deg)
	);

	`V2H_ASSERT_IMP(a_hue_range, clk, arst_n, hue.valid, hue.hue_deg < OUT_FULL_TURN)
	`V2H_ASSERT_IMP(a_ready_chain, clk, arst_n, hue.ready, vec.ready)
	`V2H_ASSERT_IMP(a_stall_needs_output, clk, arst_n, !vec.ready, hue.valid)
	`V2H_ASSERT_NXT(a_fold_filled, clk, arst_n, vec.valid && vec.ready, chain_valid[0])

endmodule

[rtl/v2h_fold.sv]
// entry stage: widens the vector and folds it into the right half plane
// depends on v2h_pkg
module v2h_fold
	import v2h_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  logic signed [IN_W-1:0] x_in,
	input  logic signed [IN_W-1:0] y_in,
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output v2h_rot_t               dn_rot
);

	logic                 valid_s1;
	v2h_rot_t             rot_s1;
	v2h_rot_t             rot_d;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	assign up_ready = !valid_s1 || dn_ready;

	always_comb begin
		xs = XW'(x_in) <<< GUARD_BITS;
		ys = XW'(y_in) <<< GUARD_BITS;
		rot_d.zero = (x_in == '0) && (y_in == '0);
		if (x_in[IN_W-1]) begin
			rot_d.x = -xs;
			rot_d.y = -ys;
			rot_d.z = DEG_HALF_TURN;
		end else begin
			rot_d.x = xs;
			rot_d.y = ys;
			rot_d.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rot_s1 <= rot_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_rot   = rot_s1;

endmodule

[rtl/v2h_cell.sv]
// one cordic vectoring micro-rotation with its own pipeline register
// depends on v2h_pkg
module v2h_cell
	import v2h_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TBL_IDX_W-1:0] stage_idx,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  v2h_rot_t             up_rot,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output v2h_rot_t             dn_rot
);

	logic                 valid_q;
	v2h_rot_t             rot_q;
	v2h_rot_t             rot_d;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [ZW-1:0] ang;

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		dx  = up_rot.y >>> stage_idx;
		dy  = up_rot.x >>> stage_idx;
		ang = signed'({{(ZW-ATAN_W){1'b0}}, ATAN_TBL[stage_idx]});
		rot_d.zero = up_rot.zero;
		if (!up_rot.y[XW-1]) begin
			rot_d.x = up_rot.x + dx;
			rot_d.y = up_rot.y - dy;
			rot_d.z = up_rot.z + ang;
		end else begin
			rot_d.x = up_rot.x - dx;
			rot_d.y = up_rot.y + dy;
			rot_d.z = up_rot.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rot_q <= rot_d;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rot   = rot_q;

endmodule

[rtl/v2h_wrap.sv]
// output stage: wraps the angle into one turn and rounds it to hue degrees
// depends on v2h_pkg
module v2h_wrap
	import v2h_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  v2h_rot_t         up_rot,
	output logic             dn_valid,
	input  logic             dn_ready,
	output logic [OUT_W-1:0] hue_deg
);

	logic                 valid_q;
	logic [OUT_W-1:0]     hue_q;
	logic signed [ZW-1:0] zw;
	logic [ZW-1:0]        zr;
	logic [RES_W-1:0]     res;
	logic [RES_W-1:0]     res_w;
	logic [OUT_W-1:0]     hue_d;

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		zw    = up_rot.z[ZW-1] ? (up_rot.z + DEG_FULL_TURN) : up_rot.z;
		zr    = unsigned'(zw) + ROUND_HALF;
		res   = zr[ZW-1:OUT_SHIFT];
		res_w = (res >= RES_W'(OUT_FULL_TURN)) ? (res - RES_W'(OUT_FULL_TURN)) : res;
		hue_d = up_rot.zero ? '0 : res_w[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			hue_q <= hue_d;
		end
	end

	assign dn_valid = valid_q;
	assign hue_deg  = hue_q;

endmodule
